FILE: rtl/core/clr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clr_pkg: shared codes for the clipped line rasterizer
// Command codes on the input channel and configuration register indexes.
// ----------------------------------------------------------------------------
package clr_pkg;

  // input command codes
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_code_t;

  // configuration register indexes
  localparam int CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_CLIP_LEFT   = 3'd0,
    CFG_CLIP_TOP    = 3'd1,
    CFG_CLIP_RIGHT  = 3'd2,
    CFG_CLIP_BOTTOM = 3'd3,
    CFG_DRAW_COLOUR = 3'd4
  } cfg_idx_t;

  localparam int ColourBits = 32;

endpackage : clr_pkg
`default_nettype wire

FILE: rtl/core/clr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clr_queue: small command queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module clr_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [Width-1:0] rdata,
  output logic             valid
);

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_r [Depth];
  logic [PtrBits-1:0] wptr_r, wptr_nxt;
  logic [PtrBits-1:0] rptr_r, rptr_nxt;
  logic [CntBits-1:0] count_r, count_nxt;
  logic               do_wr, do_rd;

  assign full  = (count_r == CntBits'(Depth));
  assign valid = (count_r != '0);
  assign rdata = mem_r[rptr_r];
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;

  // pointer and count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PtrBits'(Depth - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PtrBits'(Depth - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntBits'(Depth))
    else $error("queue count past depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a lone write");

endmodule : clr_queue
`default_nettype wire

FILE: rtl/core/clr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clr_front: request intake and line setup
// Takes requests, works out start point, direction and Bresenham lengths
// for start commands, and writes one packed entry per request to the queue.
// ----------------------------------------------------------------------------
module clr_front #(
  parameter int COORD_BITS = 15
) (
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_command,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         q_wr,
  output logic [4*COORD_BITS+5:0]      q_wdata,
  input  logic                         q_full
);

  import clr_pkg::*;

  localparam int LenBits = COORD_BITS + 1;

  typedef struct packed {
    logic                         is_step;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic [LenBits-1:0]           major;
    logic [LenBits-1:0]           minor;
    logic                         sx_neg;
    logic                         sy_neg;
    logic                         x_major;
  } entry_t;

  entry_t                    ent;
  logic signed [LenBits-1:0] diff_x, diff_y;
  logic                      x_back, y_back;
  logic [LenBits-1:0]        abs_dx, abs_dy;
  logic                      horiz, vert;

  assign in_full = q_full;
  assign q_wr    = in_push && !q_full;
  assign q_wdata = ent;

  // signed differences, one bit wider than a coordinate
  assign diff_x = {in_end_x[COORD_BITS-1], in_end_x} - {in_start_x[COORD_BITS-1], in_start_x};
  assign diff_y = {in_end_y[COORD_BITS-1], in_end_y} - {in_start_y[COORD_BITS-1], in_start_y};
  assign x_back = diff_x[LenBits-1];
  assign y_back = diff_y[LenBits-1];
  assign abs_dx = x_back ? LenBits'(-diff_x) : LenBits'(diff_x);
  assign abs_dy = y_back ? LenBits'(-diff_y) : LenBits'(diff_y);
  assign horiz  = (in_start_y == in_end_y);
  assign vert   = (in_start_x == in_end_x);

  // setup: axis lines run forward from their lesser end
  always_comb begin
    ent.is_step = (in_command == CMD_STEP);
    if (horiz) begin
      ent.x0     = x_back ? in_end_x : in_start_x;
      ent.y0     = in_start_y;
      ent.sx_neg = 1'b0;
      ent.sy_neg = 1'b0;
    end else if (vert) begin
      ent.x0     = in_start_x;
      ent.y0     = y_back ? in_end_y : in_start_y;
      ent.sx_neg = 1'b0;
      ent.sy_neg = 1'b0;
    end else begin
      ent.x0     = in_start_x;
      ent.y0     = in_start_y;
      ent.sx_neg = x_back;
      ent.sy_neg = y_back;
    end
    ent.x_major = (abs_dx >= abs_dy);
    ent.major   = ent.x_major ? abs_dx : abs_dy;
    ent.minor   = ent.x_major ? abs_dy : abs_dx;
  end

endmodule : clr_front
`default_nettype wire

FILE: rtl/core/clr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clr_back: Bresenham walker and result register
// Pops queue entries, loads the walker on start and emits one clipped pixel
// per step into the result register.
// ----------------------------------------------------------------------------
module clr_back #(
  parameter int COORD_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  logic [4*COORD_BITS+5:0]      q_rdata,
  output logic                         q_rd,
  input  logic signed [COORD_BITS-1:0] clip_left,
  input  logic signed [COORD_BITS-1:0] clip_top,
  input  logic signed [COORD_BITS-1:0] clip_right,
  input  logic signed [COORD_BITS-1:0] clip_bottom,
  input  logic [31:0]                  draw_colour,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic                         out_visible,
  output logic [31:0]                  out_pixel_colour,
  output logic                         out_last_pixel
);

  import clr_pkg::*;

  localparam int LenBits = COORD_BITS + 1;

  typedef struct packed {
    logic                         is_step;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic [LenBits-1:0]           major;
    logic [LenBits-1:0]           minor;
    logic                         sx_neg;
    logic                         sy_neg;
    logic                         x_major;
  } entry_t;

  entry_t ent;

  // walker state
  logic signed [COORD_BITS-1:0] cur_x_r, cur_x_nxt;
  logic signed [COORD_BITS-1:0] cur_y_r, cur_y_nxt;
  logic [LenBits-1:0]           err_r, err_nxt;
  logic [LenBits-1:0]           major_r, major_nxt;
  logic [LenBits-1:0]           minor_r, minor_nxt;
  logic [LenBits-1:0]           left_r, left_nxt;
  logic                         sx_neg_r, sx_neg_nxt;
  logic                         sy_neg_r, sy_neg_nxt;
  logic                         x_major_r, x_major_nxt;
  logic                         busy_r, busy_nxt;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic                         vis_r, last_r;
  logic [ColourBits-1:0]        colour_r;

  logic               emit, out_free, go, take, last, x_move, y_move, vis;
  logic [LenBits-1:0] err_sum;

  assign ent      = q_rdata;
  assign out_free = !out_valid_r || out_pop;
  assign emit     = ent.is_step && busy_r;
  assign go       = q_valid && (out_free || !emit);
  assign q_rd     = go;

  // one Bresenham step
  assign err_sum = err_r + minor_r;
  assign take    = (err_sum >= major_r);
  assign last    = (left_r <= LenBits'(1));
  assign x_move  = x_major_r || take;
  assign y_move  = !x_major_r || take;
  assign vis     = (cur_x_r >= clip_left) && (cur_x_r < clip_right) &&
                   (cur_y_r >= clip_top) && (cur_y_r < clip_bottom);

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    err_nxt       = err_r;
    major_nxt     = major_r;
    minor_nxt     = minor_r;
    left_nxt      = left_r;
    sx_neg_nxt    = sx_neg_r;
    sy_neg_nxt    = sy_neg_r;
    x_major_nxt   = x_major_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_pop;
    if (go && !ent.is_step) begin
      // load a new line, dropping any in progress
      cur_x_nxt   = ent.x0;
      cur_y_nxt   = ent.y0;
      sx_neg_nxt  = ent.sx_neg;
      sy_neg_nxt  = ent.sy_neg;
      x_major_nxt = ent.x_major;
      major_nxt   = ent.major;
      minor_nxt   = ent.minor;
      err_nxt     = ent.major >> 1;
      busy_nxt    = (ent.major != '0);
      left_nxt    = (ent.major != '0) ? ent.major + 1'b1 : '0;
    end else if (go && emit) begin
      out_valid_nxt = 1'b1;
      err_nxt       = take ? err_sum - major_r : err_sum;
      if (x_move) begin
        cur_x_nxt = cur_x_r + (sx_neg_r ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
      end
      if (y_move) begin
        cur_y_nxt = cur_y_r + (sy_neg_r ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
      end
      left_nxt = last ? '0 : left_r - 1'b1;
      busy_nxt = !last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walker payload
  always_ff @(posedge clk) begin
    cur_x_r   <= cur_x_nxt;
    cur_y_r   <= cur_y_nxt;
    err_r     <= err_nxt;
    major_r   <= major_nxt;
    minor_r   <= minor_nxt;
    sx_neg_r  <= sx_neg_nxt;
    sy_neg_r  <= sy_neg_nxt;
    x_major_r <= x_major_nxt;
  end

  // result payload, loaded when a pixel is emitted
  always_ff @(posedge clk) begin
    if (go && emit) begin
      px_r     <= cur_x_r;
      py_r     <= cur_y_r;
      vis_r    <= vis;
      last_r   <= last;
      colour_r <= draw_colour;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_pixel_x      = px_r;
  assign out_pixel_y      = py_r;
  assign out_visible      = vis_r;
  assign out_pixel_colour = colour_r;
  assign out_last_pixel   = last_r;

  // checks
  a_busy_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (left_r != '0))
    else $error("walker busy with no pixels left");

  a_err_below_major: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (err_r < major_r))
    else $error("error term not below major length");

  a_emit_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (go && emit) |=> (!out_empty && ($past(last) == out_last_pixel)))
    else $error("emitted pixel not registered");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (go && emit && last) |=> !busy_r)
    else $error("walker still busy after last pixel");

endmodule : clr_back
`default_nettype wire

FILE: rtl/core/clipped_line_rasterizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_line_rasterizer: Bresenham line walker with rectangle clipping
// Top level: configuration registers, request queue, front and back parts.
// ----------------------------------------------------------------------------
// Usage
//   Input: queue-style push/full. command = start loads two end points and
//   gives no pixel; command = step gives the next pixel of the line, or
//   nothing when no line is active (idle, finished, or zero length).
//   Output: queue-style empty/pop. Each pixel carries x, y, a visible flag
//   for the clip window [left, right) x [top, bottom), the draw colour and
//   a last-pixel flag.
//   Config: cfg_valid/cfg_ready (ready always high), cfg_index selects
//   clip_left, clip_top, clip_right, clip_bottom or draw_colour. Write only
//   while no request is in flight.
// Timing
//   A step request passes through the queue and then the result register.
//   Sustained rate is one request per cycle while the receiver pops, set
//   by the add-compare-subtract of the walker in the back part.
//   A two-entry queue sits between intake and walker, so intake keeps
//   taking requests while a pixel waits on the output; when the receiver
//   stalls the queue fills and full rises.
// Reset
//   Synchronous, active low. Queue and output empty, walker idle, clip
//   window from the least coordinate up to the greatest (excluded), colour zero.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer #(
  parameter int COORD_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_command,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  // result channel
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic                         out_visible,
  output logic [31:0]                  out_pixel_colour,
  output logic                         out_last_pixel,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);

  import clr_pkg::*;

  localparam int EntryBits = 4 * COORD_BITS + 6;
  localparam int QDepth    = 2;

  logic signed [COORD_BITS-1:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;
  logic [ColourBits-1:0]        colour_r;
  logic                         cfg_wr;

  logic                 q_wr, q_full, q_rd, q_valid;
  logic [EntryBits-1:0] q_wdata, q_rdata;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= {1'b1, {(COORD_BITS-1){1'b0}}};
      clip_top_r    <= {1'b1, {(COORD_BITS-1){1'b0}}};
      clip_right_r  <= {1'b0, {(COORD_BITS-1){1'b1}}};
      clip_bottom_r <= {1'b0, {(COORD_BITS-1){1'b1}}};
      colour_r      <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CLIP_LEFT:   clip_left_r   <= cfg_data[COORD_BITS-1:0];
        CFG_CLIP_TOP:    clip_top_r    <= cfg_data[COORD_BITS-1:0];
        CFG_CLIP_RIGHT:  clip_right_r  <= cfg_data[COORD_BITS-1:0];
        CFG_CLIP_BOTTOM: clip_bottom_r <= cfg_data[COORD_BITS-1:0];
        CFG_DRAW_COLOUR: colour_r      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // intake and setup
  clr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_push    (in_push),
    .in_full    (in_full),
    .in_command (in_command),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .q_wr       (q_wr),
    .q_wdata    (q_wdata),
    .q_full     (q_full)
  );

  // request queue
  clr_queue #(
    .Width (EntryBits),
    .Depth (QDepth)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  // walker and result register
  clr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_rdata          (q_rdata),
    .q_rd             (q_rd),
    .clip_left        (clip_left_r),
    .clip_top         (clip_top_r),
    .clip_right       (clip_right_r),
    .clip_bottom      (clip_bottom_r),
    .draw_colour      (colour_r),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_visible      (out_visible),
    .out_pixel_colour (out_pixel_colour),
    .out_last_pixel   (out_last_pixel)
  );

endmodule : clipped_line_rasterizer
`default_nettype wire
